@@ src/bccm_pkg.sv @@
// bccm_pkg: shared widths, codes, register reset values and structs of the
// bifurcation column cycle marker. No dependencies.
`default_nettype none

package bccm_pkg;

  localparam int ROWS      = 64;
  localparam int ROW_W     = $clog2(ROWS);
  localparam int TOP_W     = $clog2(ROWS + 1);
  localparam int COL_W     = 10;
  localparam int DATA_W    = 32;
  localparam int ITER_W    = 16;
  localparam int STEP_W    = ITER_W + 1;
  localparam int LIMIT_W   = 7;
  localparam int MASK_W    = 64;
  localparam int CFG_IDX_W = 3;
  localparam int OP_W      = DATA_W + 2;
  localparam int PROD_W    = 2 * OP_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_C_MIN       = 3'd0,
    CFG_C_STEP      = 3'd1,
    CFG_X_MIN       = 3'd2,
    CFG_ROW_SCALE   = 3'd3,
    CFG_INITIAL_X   = 3'd4,
    CFG_MAX_ITER    = 3'd5,
    CFG_DISCARD_CNT = 3'd6,
    CFG_STACK_LIMIT = 3'd7
  } cfg_idx_t;

  typedef enum logic [1:0] {
    OUT_CYCLE   = 2'd0,
    OUT_LIMIT   = 2'd1,
    OUT_EXHAUST = 2'd2
  } outcome_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMUL,
    ST_CADD,
    ST_SQ,
    ST_ADD,
    ST_ROW,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    MUL_COL,
    MUL_SQ,
    MUL_ROW
  } mul_op_t;

  localparam logic [DATA_W-1:0]  RST_C_MIN       = 32'hE000_0000;
  localparam logic [DATA_W-1:0]  RST_C_STEP      = 32'd590400;
  localparam logic [DATA_W-1:0]  RST_X_MIN       = 32'hE000_0000;
  localparam logic [DATA_W-1:0]  RST_ROW_SCALE   = 32'h1000_0000;
  localparam logic [DATA_W-1:0]  RST_INITIAL_X   = 32'h0000_0000;
  localparam logic [ITER_W-1:0]  RST_MAX_ITER    = 16'd1000;
  localparam logic [ITER_W-1:0]  RST_DISCARD_CNT = 16'd100;
  localparam logic [LIMIT_W-1:0] RST_STACK_LIMIT = 7'd64;

  typedef struct packed {
    logic signed [DATA_W-1:0] c_min;
    logic signed [DATA_W-1:0] c_step;
    logic signed [DATA_W-1:0] x_min;
    logic [DATA_W-1:0]        row_scale;
    logic signed [DATA_W-1:0] initial_x;
    logic [ITER_W-1:0]        max_iter;
    logic [ITER_W-1:0]        discard_count;
    logic [LIMIT_W-1:0]       stack_limit;
  } cfg_t;

  // operand request from the sequencer to the shared multiplier
  typedef struct packed {
    logic                     en;
    mul_op_t                  op;
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W:0]   diff;
    logic [COL_W-1:0]         column;
  } mul_req_t;

endpackage

`default_nettype wire

@@ src/bccm_in_if.sv @@
// bccm_in_if: column input channel, valid/ready with the column payload.
// Depends on bccm_pkg.
`default_nettype none

interface bccm_in_if;
  import bccm_pkg::*;

  logic             valid;
  logic             ready;
  logic [COL_W-1:0] column;

  modport source (output valid, output column, input ready);
  modport sink (input valid, input column, output ready);
endinterface

`default_nettype wire

@@ src/bccm_out_if.sv @@
// bccm_out_if: result channel, valid/ready with row mask and outcome code.
// Depends on bccm_pkg.
`default_nettype none

interface bccm_out_if;
  import bccm_pkg::*;

  logic              valid;
  logic              ready;
  logic [MASK_W-1:0] row_mask;
  logic [1:0]        outcome;

  modport source (output valid, output row_mask, output outcome, input ready);
  modport sink (input valid, input row_mask, input outcome, output ready);
endinterface

`default_nettype wire

@@ src/bccm_cfg_regs.sv @@
// bccm_cfg_regs: configuration register file behind the plain write port.
// Depends on bccm_pkg.
`default_nettype none

module bccm_cfg_regs (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [bccm_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [bccm_pkg::DATA_W-1:0]    cfg_wdata,
  output bccm_pkg::cfg_t                      cfg
);
  import bccm_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.c_min         <= RST_C_MIN;
      cfg_r.c_step        <= RST_C_STEP;
      cfg_r.x_min         <= RST_X_MIN;
      cfg_r.row_scale     <= RST_ROW_SCALE;
      cfg_r.initial_x     <= RST_INITIAL_X;
      cfg_r.max_iter      <= RST_MAX_ITER;
      cfg_r.discard_count <= RST_DISCARD_CNT;
      cfg_r.stack_limit   <= RST_STACK_LIMIT;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_idx))
        CFG_C_MIN:       cfg_r.c_min         <= cfg_wdata;
        CFG_C_STEP:      cfg_r.c_step        <= cfg_wdata;
        CFG_X_MIN:       cfg_r.x_min         <= cfg_wdata;
        CFG_ROW_SCALE:   cfg_r.row_scale     <= cfg_wdata;
        CFG_INITIAL_X:   cfg_r.initial_x     <= cfg_wdata;
        CFG_MAX_ITER:    cfg_r.max_iter      <= cfg_wdata[ITER_W-1:0];
        CFG_DISCARD_CNT: cfg_r.discard_count <= cfg_wdata[ITER_W-1:0];
        CFG_STACK_LIMIT: cfg_r.stack_limit   <= cfg_wdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

@@ src/bccm_mul_unit.sv @@
// bccm_mul_unit: the one shared 34x34 signed multiplier with its operand
// select and registered product. Depends on bccm_pkg.
`default_nettype none

module bccm_mul_unit (
  input  wire logic                               clk,
  input  bccm_pkg::mul_req_t                      req,
  input  bccm_pkg::cfg_t                          cfg,
  output logic signed [bccm_pkg::PROD_W-1:0]      prod
);
  import bccm_pkg::*;

  logic signed [OP_W-1:0]   op_a;
  logic signed [OP_W-1:0]   op_b;
  logic signed [PROD_W-1:0] prod_r;

  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (req.op)
      MUL_COL: begin
        op_a = signed'({{(OP_W-COL_W){1'b0}}, req.column});
        op_b = OP_W'(cfg.c_step);
      end
      MUL_SQ: begin
        op_a = OP_W'(req.x);
        op_b = OP_W'(req.x);
      end
      MUL_ROW: begin
        // difference is only used when non-negative, scale is unsigned
        op_a = OP_W'(req.diff);
        op_b = signed'({2'b00, cfg.row_scale});
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (req.en) begin
      prod_r <= op_a * op_b;
    end
  end

  assign prod = prod_r;

endmodule

`default_nettype wire

@@ src/bccm_seq.sv @@
// bccm_seq: sequencer of one column: c set-up, transient and tracked orbit
// steps, row quantisation, visited set and result register.
// Depends on bccm_pkg; drives bccm_mul_unit through a mul_req_t.
`default_nettype none

module bccm_seq (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  bccm_pkg::cfg_t                         cfg,
  input  wire logic                              in_valid,
  input  wire logic [bccm_pkg::COL_W-1:0]        in_column,
  output logic                                   in_ready,
  output bccm_pkg::mul_req_t                     mul_req,
  input  wire logic signed [bccm_pkg::PROD_W-1:0] prod,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [bccm_pkg::MASK_W-1:0]            out_row_mask,
  output logic [1:0]                             out_outcome
);
  import bccm_pkg::*;

  state_t                   state_r, state_nxt;
  logic signed [DATA_W-1:0] x_r, x_nxt;
  logic signed [DATA_W-1:0] c_r, c_nxt;
  logic [COL_W-1:0]         col_r, col_nxt;
  logic [ITER_W-1:0]        disc_r, disc_nxt;
  logic [STEP_W-1:0]        step_r, step_nxt;
  logic                     track_r, track_nxt;
  logic                     chk_r, chk_nxt;
  logic                     neg_r, neg_nxt;
  logic [ROWS-1:0]          visited_r, visited_nxt;
  logic [TOP_W-1:0]         top_r, top_nxt;
  logic [MASK_W-1:0]        res_mask_r, res_mask_nxt;
  outcome_t                 res_out_r, res_out_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [MASK_W-1:0]        out_mask_r;
  outcome_t                 out_outcome_r;
  logic                     out_load;

  logic signed [DATA_W:0]   diff;
  logic [DATA_W-1:0]        sq_sat;
  logic signed [DATA_W:0]   x_sum;
  logic signed [DATA_W-1:0] x_step;
  logic signed [42:0]       c_sum;
  logic signed [DATA_W-1:0] c_sat;
  logic [15:0]              row_hi;
  logic                     row_ok;
  logic [ROW_W-1:0]         row_idx;
  logic                     row_hit;
  logic [TOP_W-1:0]         top_inc;
  logic                     at_limit;
  logic                     exhausted;

  // x*x in Q4.28, saturated high, then plus c saturated both ways
  assign sq_sat = (prod[PROD_W-1:59] != '0) ? 32'h7FFF_FFFF : {1'b0, prod[58:28]};
  assign x_sum  = signed'({1'b0, sq_sat}) + (DATA_W+1)'(c_r);
  assign x_step = (x_sum[DATA_W] != x_sum[DATA_W-1]) ?
                  (x_sum[DATA_W] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : x_sum[DATA_W-1:0];

  assign c_sum = 43'(cfg.c_min) + prod[42:0];
  assign c_sat = (c_sum[42:31] != '0 && c_sum[42:31] != '1) ?
                 (c_sum[42] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : c_sum[DATA_W-1:0];

  assign diff = (DATA_W+1)'(x_r) - (DATA_W+1)'(cfg.x_min);

  // row = floor of Q16.52 product; a negative difference only lands on row 0
  assign row_hi   = prod[67:52];
  assign row_ok   = neg_r ? (cfg.row_scale == '0) : (row_hi < 16'(ROWS));
  assign row_idx  = neg_r ? '0 : row_hi[ROW_W-1:0];
  assign row_hit  = visited_r[row_idx];
  assign top_inc  = top_r + TOP_W'(1);
  assign at_limit = (TOP_W'(top_inc) >= TOP_W'(cfg.stack_limit)) ||
                    (top_inc >= TOP_W'(ROWS));
  assign exhausted = track_r && (step_r > {1'b0, cfg.max_iter});

  assign out_load = (state_r == ST_DONE) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt    = state_r;
    x_nxt        = x_r;
    c_nxt        = c_r;
    col_nxt      = col_r;
    disc_nxt     = disc_r;
    step_nxt     = step_r;
    track_nxt    = track_r;
    chk_nxt      = chk_r;
    neg_nxt      = neg_r;
    visited_nxt  = visited_r;
    top_nxt      = top_r;
    res_mask_nxt = res_mask_r;
    res_out_nxt  = res_out_r;
    in_ready     = 1'b0;
    mul_req.en     = 1'b0;
    mul_req.op     = MUL_SQ;
    mul_req.x      = x_r;
    mul_req.diff   = diff;
    mul_req.column = col_r;

    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          col_nxt     = in_column;
          visited_nxt = '0;
          top_nxt     = '0;
          state_nxt   = ST_CMUL;
        end
      end
      ST_CMUL: begin
        mul_req.en = 1'b1;
        mul_req.op = MUL_COL;
        state_nxt  = ST_CADD;
      end
      ST_CADD: begin
        c_nxt     = c_sat;
        x_nxt     = cfg.initial_x;
        disc_nxt  = cfg.discard_count;
        track_nxt = (cfg.discard_count == '0);
        step_nxt  = '0;
        chk_nxt   = 1'b0;
        state_nxt = ST_SQ;
      end
      ST_SQ: begin
        // the row product of the previous step is checked here, while the
        // multiplier starts on the next square
        if (chk_r && row_ok && row_hit) begin
          // every visited row was pushed, so the stack is the visited set
          res_mask_nxt = MASK_W'(visited_r);
          res_out_nxt  = OUT_CYCLE;
          state_nxt    = ST_DONE;
        end else if (chk_r && row_ok && at_limit) begin
          res_mask_nxt = '0;
          res_out_nxt  = OUT_LIMIT;
          state_nxt    = ST_DONE;
        end else if (exhausted) begin
          res_mask_nxt = '0;
          res_out_nxt  = OUT_EXHAUST;
          state_nxt    = ST_DONE;
        end else begin
          if (chk_r && row_ok) begin
            visited_nxt[row_idx] = 1'b1;
            top_nxt              = top_inc;
          end
          chk_nxt    = 1'b0;
          mul_req.en = 1'b1;
          mul_req.op = MUL_SQ;
          state_nxt  = ST_ADD;
        end
      end
      ST_ADD: begin
        x_nxt = x_step;
        if (track_r) begin
          state_nxt = ST_ROW;
        end else begin
          disc_nxt = disc_r - ITER_W'(1);
          if (disc_r == ITER_W'(1)) begin
            track_nxt = 1'b1;
          end
          state_nxt = ST_SQ;
        end
      end
      ST_ROW: begin
        mul_req.en = 1'b1;
        mul_req.op = MUL_ROW;
        neg_nxt    = diff[DATA_W];
        chk_nxt    = 1'b1;
        step_nxt   = step_r + STEP_W'(1);
        state_nxt  = ST_SQ;
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      disc_r      <= '0;
      step_r      <= '0;
      track_r     <= 1'b0;
      chk_r       <= 1'b0;
      neg_r       <= 1'b0;
      visited_r   <= '0;
      top_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      disc_r      <= disc_nxt;
      step_r      <= step_nxt;
      track_r     <= track_nxt;
      chk_r       <= chk_nxt;
      neg_r       <= neg_nxt;
      visited_r   <= visited_nxt;
      top_r       <= top_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r        <= x_nxt;
    c_r        <= c_nxt;
    col_r      <= col_nxt;
    res_mask_r <= res_mask_nxt;
    res_out_r  <= res_out_nxt;
    if (out_load) begin
      out_mask_r    <= res_mask_r;
      out_outcome_r <= res_out_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_row_mask = out_mask_r;
  assign out_outcome  = out_outcome_r;

endmodule

`default_nettype wire

@@ src/bifurcation_column_cycle_marker_core.sv @@
// bifurcation_column_cycle_marker_core: top level, config registers, shared
// multiplier and sequencer. Depends on bccm_pkg, bccm_in_if, bccm_out_if, bccm_cfg_regs, bccm_mul_unit, bccm_seq.
//
//   port       dir   handshake      payload
//   in_ch      sink  valid/ready    column[9:0]
//   out_ch     src   valid/ready    row_mask[63:0], outcome[1:0]
//   cfg_*      in    cfg_we         cfg_idx[2:0], cfg_wdata[31:0]
//
// a column runs c set-up, square and add per discarded step, then square,
// add and row scale per tracked step, and hands over the result; every orbit
// step uses the single multiplier, twice per tracked step (square, row scale)
// in_ch.ready is high only while the sequencer is idle; one finished result
// may wait in the output register while the next column is taken
// reset is synchronous on rst_n and restores the register defaults
`default_nettype none

module bifurcation_column_cycle_marker_core (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  bccm_in_if.sink                             in_ch,
  bccm_out_if.source                          out_ch,
  input  wire logic                           cfg_we,
  input  wire logic [bccm_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [bccm_pkg::DATA_W-1:0]    cfg_wdata
);
  import bccm_pkg::*;

  cfg_t                     cfg;
  mul_req_t                 mul_req;
  logic signed [PROD_W-1:0] prod;
  logic                     in_ready;
  logic                     out_valid;
  logic [MASK_W-1:0]        out_row_mask;
  logic [1:0]               out_outcome;

  bccm_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  bccm_mul_unit u_mul (
    .clk  (clk),
    .req  (mul_req),
    .cfg  (cfg),
    .prod (prod)
  );

  bccm_seq u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg),
    .in_valid     (in_ch.valid),
    .in_column    (in_ch.column),
    .in_ready     (in_ready),
    .mul_req      (mul_req),
    .prod         (prod),
    .out_valid    (out_valid),
    .out_ready    (out_ch.ready),
    .out_row_mask (out_row_mask),
    .out_outcome  (out_outcome)
  );

  assign in_ch.ready     = in_ready;
  assign out_ch.valid    = out_valid;
  assign out_ch.row_mask = out_row_mask;
  assign out_ch.outcome  = out_outcome;

endmodule

`default_nettype wire

@@ src/bccm_checker.sv @@
// bccm_checker: port-level checks of the column marker, bound to the top
// level below. Depends on bccm_pkg.
`default_nettype none

module bccm_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_valid,
  input wire logic                        in_ready,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [bccm_pkg::MASK_W-1:0] out_row_mask,
  input wire logic [1:0]                  out_outcome
);
  import bccm_pkg::*;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_row_mask) && $stable(out_outcome))
    else $error("result beat changed while stalled");

  // one column at a time
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again right after a beat");

  // only a found cycle marks rows
  a_nomark: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_outcome != OUT_CYCLE) |-> out_row_mask == '0)
    else $error("rows marked without a cycle");

  // a revisit needs at least one visited row
  a_mark: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_outcome == OUT_CYCLE) |-> out_row_mask != '0)
    else $error("cycle reported with empty mask");

  // no result straight after a column is taken
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_valid && in_ready))
    else $error("result too soon after input beat");

endmodule

bind bifurcation_column_cycle_marker_core bccm_checker u_bccm_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_row_mask (out_ch.row_mask),
  .out_outcome  (out_ch.outcome)
);

`default_nettype wire

@@ tb/tb_top.sv @@
// tb_top: self-checking bench for the bifurcation column cycle marker core.
// Drives columns, predicts each row mask and outcome from a local orbit
// tracer, checks every result beat. Needs bccm_pkg, bccm_in_if, bccm_out_if and the core.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import bccm_pkg::*;

  localparam longint WORD_MAX = 64'sd2147483647;
  localparam longint WORD_MIN = -64'sd2147483648;

  typedef struct packed {
    logic [MASK_W-1:0] row_mask;
    outcome_t          outcome;
  } column_mark_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  cfg_idx_t             cfg_idx = CFG_C_MIN;
  logic [DATA_W-1:0]    cfg_wdata = '0;

  logic                 src_valid = 1'b0;
  logic [COL_W-1:0]     src_column = '0;
  logic                 snk_ready = 1'b0;

  bccm_in_if  in_ch ();
  bccm_out_if out_ch ();

  assign in_ch.valid  = src_valid;
  assign in_ch.column = src_column;
  assign out_ch.ready = snk_ready;

  bifurcation_column_cycle_marker_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #6ns clk = 1'b1;
    #6ns clk = 1'b0;
  end

  cfg_t               diagram_cfg;
  logic [COL_W-1:0]   columns_to_send[$];
  column_mark_t       predicted_marks[$];
  column_mark_t       oldest_mark;
  bit                 quiet_run = 1'b0;
  bit                 hold_for_idle = 1'b0;
  int                 src_gap = 0;
  int                 snk_gap = 0;
  int                 mismatch_count = 0;
  int                 columns_taken = 0;
  int                 cycles_marked = 0;
  int                 limits_hit = 0;
  int                 orbits_exhausted = 0;
  int                 settings_used = 0;
  longint             cycle_count = 0;
  longint             cycle_limit = 50000;

  function automatic int sat_word(input longint v);
    if (v > WORD_MAX) return int'(WORD_MAX);
    if (v < WORD_MIN) return int'(WORD_MIN);
    return int'(v);
  endfunction

  // x*x truncated to Q4.28 and clipped, then the clipped sum with c
  function automatic int quad_step(input int x, input int c);
    longint sq;
    sq = (longint'(x) * longint'(x)) >>> 28;
    if (sq > WORD_MAX) sq = WORD_MAX;
    return sat_word(sq + longint'(c));
  endfunction

  // runs the whole orbit of one column; the stack always holds exactly the
  // visited rows, so the mask on a revisit is the visited set
  function automatic column_mark_t trace_column_orbit(input logic [COL_W-1:0] col);
    column_mark_t      mark;
    int                c;
    int                x;
    int                i;
    int                step;
    int                row;
    int                depth;
    bit                settled;
    longint            diff;
    logic [63:0]       scaled;
    logic [ROWS-1:0]   seen;
    mark.row_mask = '0;
    mark.outcome  = OUT_EXHAUST;
    seen    = '0;
    depth   = 0;
    settled = 1'b0;
    c = sat_word(longint'(diagram_cfg.c_min)
                 + longint'(col) * longint'(diagram_cfg.c_step));
    x = diagram_cfg.initial_x;
    for (i = 0; i < int'(diagram_cfg.discard_count); i++)
      x = quad_step(x, c);
    for (step = 0; step <= int'(diagram_cfg.max_iter) && !settled; step++) begin
      x = quad_step(x, c);
      diff = longint'(x) - longint'(diagram_cfg.x_min);
      if (diff < 0) begin
        // below the window: only a zero scale pulls it onto row zero
        row = (diagram_cfg.row_scale == '0) ? 0 : -1;
      end else begin
        scaled = diff;
        scaled = scaled * {32'd0, diagram_cfg.row_scale};
        row = (scaled[63:52] < ROWS) ? int'(scaled[63:52]) : -1;
      end
      if (row >= 0) begin
        if (!seen[row]) begin
          seen[row] = 1'b1;
          depth++;
          if (depth >= int'(diagram_cfg.stack_limit) || depth >= ROWS) begin
            mark.outcome = OUT_LIMIT;
            settled = 1'b1;
          end
        end else begin
          mark.row_mask = seen;
          mark.outcome  = OUT_CYCLE;
          settled = 1'b1;
        end
      end
    end
    return mark;
  endfunction

  task automatic write_reg(input cfg_idx_t idx, input logic [DATA_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
  endtask

  // narrow registers get junk above their width, which the block drops
  task automatic program_cfg(input cfg_t c);
    logic [DATA_W-1:0] junk;
    junk = $urandom();
    write_reg(CFG_C_MIN, c.c_min);
    write_reg(CFG_C_STEP, c.c_step);
    write_reg(CFG_X_MIN, c.x_min);
    write_reg(CFG_ROW_SCALE, c.row_scale);
    write_reg(CFG_INITIAL_X, c.initial_x);
    write_reg(CFG_MAX_ITER, {junk[31:16], c.max_iter});
    write_reg(CFG_DISCARD_CNT, {junk[15:0], c.discard_count});
    write_reg(CFG_STACK_LIMIT, {junk[24:0], c.stack_limit});
    @(posedge clk);
    cfg_we <= 1'b0;
    diagram_cfg = c;
    settings_used++;
  endtask

  task automatic queue_column(input logic [COL_W-1:0] col);
    columns_to_send.push_back(col);
    cycle_limit += 4 * (64 + 2 * longint'(diagram_cfg.discard_count)
                   + 3 * (longint'(diagram_cfg.max_iter) + 1));
  endtask

  // sender holds off until every predicted mark has come back
  task automatic wait_drained();
    do @(negedge clk);
    while (columns_to_send.size() != 0 || src_valid || predicted_marks.size() != 0);
  endtask

  // column driver
  always @(posedge clk) begin
    if (!rst_n) begin
      src_valid <= 1'b0;
    end else begin
      if (src_valid && in_ch.ready) begin
        predicted_marks.push_back(trace_column_orbit(src_column));
        columns_taken++;
      end
      if (!src_valid || in_ch.ready) begin
        if (src_gap != 0) begin
          src_gap--;
          src_valid <= 1'b0;
        end else if (hold_for_idle && (src_valid || !in_ch.ready)) begin
          src_valid <= 1'b0;
        end else if (hold_for_idle) begin
          // block has just gone idle: leave it idle for a short burst
          hold_for_idle = 1'b0;
          src_gap = $urandom_range(0, 5);
          src_valid <= 1'b0;
        end else if (columns_to_send.size() != 0) begin
          src_valid  <= 1'b1;
          src_column <= columns_to_send.pop_front();
          if (!quiet_run) begin
            case ($urandom_range(0, 3))
              0: hold_for_idle = 1'b1;
              1: src_gap = $urandom_range(1, 6);
              default: ;
            endcase
          end
        end else begin
          src_valid <= 1'b0;
        end
      end
    end
  end

  // result side back-pressure
  always @(posedge clk) begin
    if (snk_gap != 0) begin
      snk_gap--;
      snk_ready <= 1'b0;
    end else if (!quiet_run && $urandom_range(0, 5) == 0) begin
      snk_gap = $urandom_range(0, 5);
      snk_ready <= 1'b0;
    end else begin
      snk_ready <= 1'b1;
    end
  end

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (predicted_marks.size() == 0) begin
        $error("result beat with no column outstanding: row_mask %h outcome %0d",
               out_ch.row_mask, out_ch.outcome);
        mismatch_count++;
      end else begin
        oldest_mark = predicted_marks.pop_front();
        if (out_ch.row_mask !== oldest_mark.row_mask) begin
          $error("row_mask: expected %h, got %h", oldest_mark.row_mask, out_ch.row_mask);
          mismatch_count++;
        end
        if (out_ch.outcome !== oldest_mark.outcome) begin
          $error("outcome: expected %0d, got %0d", oldest_mark.outcome, out_ch.outcome);
          mismatch_count++;
        end
        case (oldest_mark.outcome)
          OUT_CYCLE: cycles_marked++;
          OUT_LIMIT: limits_hit++;
          default:   orbits_exhausted++;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > cycle_limit) begin
      $display("timeout after %0d cycles, %0d marks outstanding",
               cycle_count, predicted_marks.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    cfg_t reset_cfg;
    cfg_t next_cfg;
    int   ph;
    int   n;
    reset_cfg.c_min         = RST_C_MIN;
    reset_cfg.c_step        = RST_C_STEP;
    reset_cfg.x_min         = RST_X_MIN;
    reset_cfg.row_scale     = RST_ROW_SCALE;
    reset_cfg.initial_x     = RST_INITIAL_X;
    reset_cfg.max_iter      = RST_MAX_ITER;
    reset_cfg.discard_count = RST_DISCARD_CNT;
    reset_cfg.stack_limit   = RST_STACK_LIMIT;
    diagram_cfg = reset_cfg;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // register defaults: full diagram across c = -2 .. 0.25
    queue_column(10'd0);
    queue_column(10'd1023);
    queue_column(10'd512);
    queue_column(10'd900);
    queue_column(10'd1000);
    queue_column(10'd300);
    wait_drained();

    // every register at an extreme: c and the square clip, row far out of window
    next_cfg = reset_cfg;
    next_cfg.c_min         = 32'sh7FFF_FFFF;
    next_cfg.c_step        = 32'sh7FFF_FFFF;
    next_cfg.x_min         = 32'sh8000_0000;
    next_cfg.row_scale     = 32'hFFFF_FFFF;
    next_cfg.initial_x     = 32'sh8000_0000;
    next_cfg.max_iter      = 16'd0;
    next_cfg.discard_count = 16'd0;
    next_cfg.stack_limit   = 7'd0;
    program_cfg(next_cfg);
    queue_column(10'd0);
    queue_column(10'd1023);
    wait_drained();

    // c clipped low, zero scale maps every x onto row zero
    next_cfg.c_min         = 32'sh8000_0000;
    next_cfg.c_step        = 32'sh8000_0000;
    next_cfg.x_min         = 32'sh7FFF_FFFF;
    next_cfg.row_scale     = 32'h0000_0000;
    next_cfg.initial_x     = 32'sh7FFF_FFFF;
    next_cfg.max_iter      = 16'd5;
    next_cfg.discard_count = 16'd2;
    next_cfg.stack_limit   = 7'd127;
    program_cfg(next_cfg);
    queue_column(10'd0);
    queue_column(10'd1023);
    queue_column(10'd1);
    wait_drained();

    // same with a tiny scale: every row negative, orbit runs out
    next_cfg.row_scale = 32'h0000_0001;
    program_cfg(next_cfg);
    queue_column(10'd5);
    queue_column(10'd700);
    wait_drained();

    // longest transient, then a stack of one
    next_cfg = reset_cfg;
    next_cfg.discard_count = 16'hFFFF;
    next_cfg.max_iter      = 16'hFFFF;
    next_cfg.stack_limit   = 7'd1;
    program_cfg(next_cfg);
    queue_column(10'd1000);
    wait_drained();

    // stack limit of zero acts as one
    next_cfg.discard_count = 16'd3;
    next_cfg.max_iter      = 16'd40;
    next_cfg.stack_limit   = 7'd0;
    program_cfg(next_cfg);
    queue_column(10'd1000);
    queue_column(10'd600);
    wait_drained();

    for (ph = 0; ph < 7; ph++) begin
      next_cfg = diagram_cfg;
      if (ph == 2) begin
        // raw noise in every register but the two counts, which stay at most 60
        next_cfg.c_min         = $urandom();
        next_cfg.c_step        = $urandom();
        next_cfg.x_min         = $urandom();
        next_cfg.row_scale     = $urandom();
        next_cfg.initial_x     = $urandom();
        next_cfg.max_iter      = ITER_W'($urandom_range(0, 60));
        next_cfg.discard_count = ITER_W'($urandom_range(0, 60));
        next_cfg.stack_limit   = LIMIT_W'($urandom());
      end else begin
        next_cfg.c_min     = 32'hE000_0000 + $urandom_range(0, 32'h1000_0000) - 32'h0800_0000;
        next_cfg.c_step    = $urandom_range(32'h0000_1000, 32'h0014_0000);
        next_cfg.x_min     = 32'hE000_0000 + $urandom_range(0, 32'h0400_0000) - 32'h0200_0000;
        next_cfg.row_scale = $urandom_range(32'h0800_0000, 32'h2000_0000);
        next_cfg.initial_x = $urandom_range(0, 32'h2000_0000) - 32'h1000_0000;
        next_cfg.max_iter      = ITER_W'($urandom_range(0, 300));
        next_cfg.discard_count = ITER_W'($urandom_range(0, 150));
        case ($urandom_range(0, 5))
          0:       next_cfg.stack_limit = 7'd0;
          1:       next_cfg.stack_limit = 7'd127;
          2:       next_cfg.stack_limit = 7'd64;
          default: next_cfg.stack_limit = LIMIT_W'($urandom_range(1, 64));
        endcase
        if (ph == 4) begin
          // narrow window somewhere in [-2, 2] at fine row pitch
          next_cfg.x_min     = $urandom_range(0, 32'h4000_0000) - 32'h2000_0000;
          next_cfg.row_scale = $urandom_range(32'h4000_0000, 32'hFFFF_FFFF);
        end
      end
      program_cfg(next_cfg);
      quiet_run = (ph == 6);
      for (n = 0; n < 36; n++)
        queue_column(COL_W'($urandom_range(0, 1023)));
      wait_drained();
    end

    repeat (40) @(posedge clk);
    $display("covered %0d columns over %0d register settings", columns_taken, settings_used);
    $display("outcomes: %0d cycles marked, %0d stack limits, %0d exhausted",
             cycles_marked, limits_hit, orbits_exhausted);
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
